@@ rtl/bssm_pkg.sv @@
// ============================================================================
// bssm_pkg
// Shared widths, codes and constants of the buffer slew spike monitor.
// ============================================================================
package bssm_pkg;

    localparam int SampleWidth  = 13;
    localparam int DeltaWidth   = 13;
    localparam int ThreshWidth  = 13;
    localparam int MvWidth      = 12;
    localparam int CountWidth   = 32;
    localparam int CodeWidth    = 12;
    localparam int ProductWidth = 24;
    localparam int CfgIdxWidth  = 1;

    typedef logic [1:0] alert_t;
    localparam alert_t AlertNone     = 2'd0;
    localparam alert_t AlertWarning  = 2'd1;
    localparam alert_t AlertCritical = 2'd2;

    typedef logic [CfgIdxWidth-1:0] cfg_idx_t;
    localparam cfg_idx_t RegWarningThreshold  = 1'd0;
    localparam cfg_idx_t RegCriticalThreshold = 1'd1;

    localparam logic [ThreshWidth-1:0] WarningReset  = 13'd100;
    localparam logic [ThreshWidth-1:0] CriticalReset = 13'd1000;

    localparam logic [CodeWidth-1:0]    RawFullScale = 12'd4095;
    localparam logic [ProductWidth-1:0] MvFullScale  = 24'd3600;

endpackage

@@ rtl/bssm_sample_if.sv @@
// ============================================================================
// bssm_sample_if
// Sample channel: one ADC sample per transaction with an end-of-buffer flag.
// ============================================================================
interface bssm_sample_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [bssm_pkg::SampleWidth-1:0]  sample;
    logic                                     end_of_buffer;

    modport source (output valid, output sample, output end_of_buffer, input ready);
    modport sink   (input valid, input sample, input end_of_buffer, output ready);
endinterface

@@ rtl/bssm_result_if.sv @@
// ============================================================================
// bssm_result_if
// Result channel: one buffer summary per transaction.
// ============================================================================
interface bssm_result_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [bssm_pkg::SampleWidth-1:0]  last_raw;
    logic        [bssm_pkg::MvWidth-1:0]      millivolts;
    logic        [bssm_pkg::DeltaWidth-1:0]   peak_step;
    bssm_pkg::alert_t                         alert_level;
    logic        [bssm_pkg::CountWidth-1:0]   buffers_done;

    modport source (output valid, output last_raw, output millivolts, output peak_step,
                    output alert_level, output buffers_done, input ready);
    modport sink   (input valid, input last_raw, input millivolts, input peak_step,
                    input alert_level, input buffers_done, output ready);
endinterface

@@ rtl/bssm_cfg_if.sv @@
// ============================================================================
// bssm_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
interface bssm_cfg_if;
    logic                                    valid;
    logic                                    ready;
    bssm_pkg::cfg_idx_t                      index;
    logic [bssm_pkg::ThreshWidth-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/buffer_slew_spike_monitor.sv @@
// ============================================================================
// buffer_slew_spike_monitor
// Tracks the largest step between consecutive samples of a buffer and emits
// a summary with millivolt reading, alert level and buffer count per buffer.
// ============================================================================
// One sample is taken every cycle while sample ready is high. The slew
// tracker updates at the sample transaction itself; a buffer-ending sample
// then passes an input register (clamp and scale product) and the result
// register (divide by 4095 via reciprocal and one correction, threshold
// compare) before its summary appears. Sample ready drops only while both
// stages hold summaries and the result channel stalls. Config writes are
// always accepted; write them only while no buffer summary is pending.
// ============================================================================
module buffer_slew_spike_monitor (
    input  logic                  clk,
    input  logic                  rst_n,
    bssm_sample_if.sink           samples,
    bssm_result_if.source         results,
    bssm_cfg_if.sink              cfg
);

    localparam int SW = bssm_pkg::SampleWidth;
    localparam int DW = bssm_pkg::DeltaWidth;
    localparam int PW = bssm_pkg::ProductWidth;

    logic [bssm_pkg::ThreshWidth-1:0] warn_reg;
    logic [bssm_pkg::ThreshWidth-1:0] crit_reg;

    logic signed [SW-1:0]             prev_reg;
    logic                             start_reg;
    logic [DW-1:0]                    run_max_reg;
    logic [DW-1:0]                    run_max_next;
    logic [bssm_pkg::CountWidth-1:0]  count_reg;

    logic                             s1_valid_reg;
    logic signed [SW-1:0]             s1_raw_reg;
    logic [PW-1:0]                    s1_prod_reg;
    logic [DW-1:0]                    s1_max_reg;
    logic [bssm_pkg::CountWidth-1:0]  s1_count_reg;

    logic                             out_valid_reg;
    logic signed [SW-1:0]             out_raw_reg;
    logic [bssm_pkg::MvWidth-1:0]     out_mv_reg;
    logic [DW-1:0]                    out_max_reg;
    bssm_pkg::alert_t                 out_alert_reg;
    logic [bssm_pkg::CountWidth-1:0]  out_count_reg;

    logic                             out_free;
    logic                             out_load;
    logic                             in_accept;
    logic                             s1_load;

    logic signed [SW:0]               diff;
    logic [SW:0]                      abs_diff;
    logic [DW-1:0]                    step;
    logic [bssm_pkg::CodeWidth-1:0]   code;

    logic [PW:0]                      quo_sum;
    logic [DW-1:0]                    quo_est;
    logic [PW:0]                      quo_back;
    logic [PW:0]                      remainder;
    logic [DW-1:0]                    quo_fix;
    bssm_pkg::alert_t                 alert;

    assign out_free  = !out_valid_reg || results.ready;
    assign out_load  = s1_valid_reg && out_free;
    assign samples.ready = !s1_valid_reg || out_free;
    assign in_accept = samples.valid && samples.ready;
    assign s1_load   = in_accept && samples.end_of_buffer;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        diff     = {samples.sample[SW-1], samples.sample} - {prev_reg[SW-1], prev_reg};
        abs_diff = diff[SW] ? (~diff + 1'b1) : diff;
        step     = abs_diff[DW-1:0];
        if (start_reg)
        begin
            run_max_next = '0;
        end
        else if (step > run_max_reg)
        begin
            run_max_next = step;
        end
        else
        begin
            run_max_next = run_max_reg;
        end
        code = samples.sample[SW-1] ? '0 : samples.sample[bssm_pkg::CodeWidth-1:0];
    end

    always_comb
    begin
        quo_sum   = {1'b0, s1_prod_reg} + {13'd0, s1_prod_reg[PW-1:12]};
        quo_est   = quo_sum[PW:12];
        quo_back  = {quo_est, 12'd0} - {12'd0, quo_est};
        remainder = {1'b0, s1_prod_reg} - quo_back;
        quo_fix   = (remainder >= {13'd0, bssm_pkg::RawFullScale}) ? quo_est + 1'b1 : quo_est;
        if (s1_max_reg > crit_reg)
        begin
            alert = bssm_pkg::AlertCritical;
        end
        else if (s1_max_reg > warn_reg)
        begin
            alert = bssm_pkg::AlertWarning;
        end
        else
        begin
            alert = bssm_pkg::AlertNone;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_reg      <= bssm_pkg::WarningReset;
            crit_reg      <= bssm_pkg::CriticalReset;
            start_reg     <= 1'b1;
            run_max_reg   <= '0;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    bssm_pkg::RegWarningThreshold:  warn_reg <= cfg.data;
                    bssm_pkg::RegCriticalThreshold: crit_reg <= cfg.data;
                    default: ;
                endcase
            end
            if (in_accept)
            begin
                if (samples.end_of_buffer)
                begin
                    start_reg   <= 1'b1;
                    run_max_reg <= '0;
                    count_reg   <= count_reg + 1'b1;
                end
                else
                begin
                    start_reg   <= 1'b0;
                    run_max_reg <= run_max_next;
                end
            end
            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            prev_reg <= samples.sample;
        end
        if (s1_load)
        begin
            s1_raw_reg   <= samples.sample;
            s1_prod_reg  <= {12'd0, code} * bssm_pkg::MvFullScale;
            s1_max_reg   <= run_max_next;
            s1_count_reg <= count_reg + 1'b1;
        end
        if (out_load)
        begin
            out_raw_reg   <= s1_raw_reg;
            out_mv_reg    <= quo_fix[bssm_pkg::MvWidth-1:0];
            out_max_reg   <= s1_max_reg;
            out_alert_reg <= alert;
            out_count_reg <= s1_count_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.last_raw     = out_raw_reg;
    assign results.millivolts   = out_mv_reg;
    assign results.peak_step    = out_max_reg;
    assign results.alert_level  = out_alert_reg;
    assign results.buffers_done = out_count_reg;

endmodule
